### src/hpdc_pkg.sv
package hpdc_pkg;

	localparam int unsigned MaskW = 19;
	localparam int unsigned VsidW = 24;
	localparam int unsigned SlotW = 3;

	localparam logic FUNC_CHECK = 1'b0;
	localparam logic FUNC_LOAD  = 1'b1;

	localparam logic [MaskW-1:0] HASH_MASK_RESET = 19'h003ff;

	localparam logic [31:0] PHYS_MEM1_END    = 32'h0180_0000;
	localparam logic [31:0] PHYS_MEM2_BASE   = 32'h1000_0000;
	localparam logic [31:0] PHYS_MEM2_END    = 32'h1400_0000;
	localparam logic [31:0] PHYS_DEV_BASE    = 32'h0c00_0000;
	localparam logic [31:0] PHYS_DEV_END     = 32'h0e00_0000;

	localparam logic [31:0] WIN0_BASE = 32'ha000_0000;
	localparam logic [31:0] WIN0_END  = 32'ha000_4000;
	localparam logic [31:0] WIN1_BASE = 32'hc000_0000;
	localparam logic [31:0] WIN1_END  = 32'hc180_0000;
	localparam logic [31:0] WIN2_BASE = 32'hcc00_0000;
	localparam logic [31:0] WIN2_END  = 32'hcd80_0000;
	localparam logic [31:0] WIN3_BASE = 32'hd000_0000;
	localparam logic [31:0] WIN3_END  = 32'hd400_0000;

	typedef struct packed {
		logic             func;
		logic [SlotW-1:0] vsid_slot;
		logic [VsidW-1:0] vsid_value;
		logic [MaskW-1:0] group_index;
		logic [31:0]      pte_high;
		logic [31:0]      pte_low;
	} in_item_t;

	typedef struct packed {
		logic             entry_valid;
		logic [VsidW-1:0] vsid;
		logic [15:0]      page_index;
		logic [19:0]      real_page;
		logic             secondary;
		logic [3:0]       segment;
		logic             is_kernel;
		logic [31:0]      eff_addr;
		logic             api_mismatch;
		logic             bad_real_page;
		logic             in_loader_window;
	} out_item_t;

	typedef struct packed {
		logic             hit;
		logic [SlotW-1:0] slot;
	} vsid_match_t;

endpackage

### src/hpdc_vsid_table.sv
module hpdc_vsid_table #(
	parameter int unsigned KERNEL_SEGMENTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load_en,
	input  logic [hpdc_pkg::SlotW-1:0] load_slot,
	input  logic [hpdc_pkg::VsidW-1:0] load_value,
	input  logic [hpdc_pkg::VsidW-1:0] query_vsid,
	output hpdc_pkg::vsid_match_t      match
);
	import hpdc_pkg::*;

	logic [VsidW-1:0] vsids_q [KERNEL_SEGMENTS];
	logic             slot_ok;

	assign slot_ok = {29'd0, load_slot} < KERNEL_SEGMENTS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KERNEL_SEGMENTS; i++) begin
				vsids_q[i] <= '0;
			end
		end else if (load_en && slot_ok) begin
			for (int i = 0; i < KERNEL_SEGMENTS; i++) begin
				if (load_slot == SlotW'(i)) begin
					vsids_q[i] <= load_value;
				end
			end
		end
	end

	// The lowest matching slot wins, so scan from the top down.
	always_comb begin
		match = '0;
		for (int i = KERNEL_SEGMENTS - 1; i >= 0; i--) begin
			if (vsids_q[i] == query_vsid) begin
				match.hit  = 1'b1;
				match.slot = SlotW'(i);
			end
		end
	end

endmodule

### src/hpdc_decode.sv
module hpdc_decode (
	input  hpdc_pkg::in_item_t          item,
	input  logic [hpdc_pkg::MaskW-1:0]  hash_mask,
	input  hpdc_pkg::vsid_match_t       match,
	output hpdc_pkg::out_item_t         result
);
	import hpdc_pkg::*;

	logic [VsidW-1:0] vsid;
	logic             sec;
	logic [5:0]       api;
	logic [19:0]      rpn;
	logic [MaskW-1:0] prim;
	logic [MaskW-1:0] pil;
	logic [15:0]      pidx;
	logic [5:0]       overlap;
	logic             mism;
	logic [3:0]       seg;
	logic [31:0]      ea;
	logic [31:0]      phys;
	logic             phys_ok;
	logic             win;

	always_comb begin
		vsid    = item.pte_high[30:7];
		sec     = item.pte_high[6];
		api     = item.pte_high[5:0];
		rpn     = item.pte_low[31:12];
		prim    = sec ? (~item.group_index & hash_mask) : (item.group_index & hash_mask);
		pil     = (prim ^ vsid[MaskW-1:0]) & hash_mask;
		pidx    = {api, pil[9:0]};
		overlap = hash_mask[15:10];
		mism    = (overlap != '0) && ((pil[15:10] & overlap) != (api & overlap));
		seg     = match.hit ? {1'b1, match.slot} : 4'd0;
		ea      = {seg, pidx, 12'd0};
		phys    = {rpn, 12'd0};
		phys_ok = (phys < PHYS_MEM1_END)
			|| (phys >= PHYS_MEM2_BASE && phys < PHYS_MEM2_END)
			|| (phys >= PHYS_DEV_BASE && phys < PHYS_DEV_END);
		win     = (ea >= WIN0_BASE && ea < WIN0_END)
			|| (ea >= WIN1_BASE && ea < WIN1_END)
			|| (ea >= WIN2_BASE && ea < WIN2_END)
			|| (ea >= WIN3_BASE && ea < WIN3_END);

		result = '0;
		if (item.pte_high[31]) begin
			result.entry_valid      = 1'b1;
			result.vsid             = vsid;
			result.page_index       = pidx;
			result.real_page        = rpn;
			result.secondary        = sec;
			result.segment          = seg;
			result.is_kernel        = match.hit;
			result.eff_addr         = ea;
			result.api_mismatch     = mism;
			result.bad_real_page    = !phys_ok;
			result.in_loader_window = match.hit && win;
		end
	end

endmodule

### src/hashed_pte_decode_check.sv
// Channel  Direction  Handshake           Payload
// in       to block   in_valid/in_stall   in_item  (check or VSID load)
// out      from block out_valid/out_stall out_item (one per check item)
// cfg      to block   cfg_we              cfg_data (hash mask)
//
// One item is accepted per cycle while in_stall is low; a check item passes from the
// input register into the result register and from there shows on out_item.
// A load item writes the VSID table as it leaves the input register.
// arst_n clears the valid flags, the VSID table and sets the mask to 0x3ff.
// A stall on out holds the result register, and in_stall rises only when a
// check item in the input register cannot move into it.
module hashed_pte_decode_check #(
	parameter int unsigned KERNEL_SEGMENTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  hpdc_pkg::in_item_t         in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output hpdc_pkg::out_item_t        out_item,
	input  logic                       cfg_we,
	input  logic [hpdc_pkg::MaskW-1:0] cfg_data
);
	import hpdc_pkg::*;

	logic [MaskW-1:0] hash_mask_q;
	logic             valid_s1;
	in_item_t         item_s1;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             is_load_s1;
	logic             adv_s1;
	vsid_match_t      match;
	out_item_t        result;

	assign is_load_s1 = item_s1.func == FUNC_LOAD;
	assign adv_s1     = valid_s1 && (is_load_s1 || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !adv_s1;
	assign out_valid  = out_valid_q;
	assign out_item   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mask_q <= HASH_MASK_RESET;
		end else if (cfg_we) begin
			hash_mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	hpdc_vsid_table #(
		.KERNEL_SEGMENTS(KERNEL_SEGMENTS)
	) u_vsid_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_en   (adv_s1 && is_load_s1),
		.load_slot (item_s1.vsid_slot),
		.load_value(item_s1.vsid_value),
		.query_vsid(item_s1.pte_high[30:7]),
		.match     (match)
	);

	hpdc_decode u_decode (
		.item     (item_s1),
		.hash_mask(hash_mask_q),
		.match    (match),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && !is_load_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && !is_load_s1) begin
			out_q <= result;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && !is_load_s1 && out_valid_q)
		else $error("input stalled without a blocked check item");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.entry_valid |-> out_q == '0)
		else $error("invalid entry item carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.in_loader_window |-> out_q.is_kernel)
		else $error("loader window flag set on a user entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.is_kernel == out_q.segment[3])
			&& (out_q.is_kernel || out_q.segment == 4'd0))
		else $error("segment disagrees with kernel match");

endmodule
